// ===== rtl/lms_pkg.sv =====
// shared types, register indexes and microcode table of the orbit sampler
package lms_pkg;

  // configuration register indexes
  localparam int CFG_INDEX_BITS = 2;
  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
  localparam cfg_index_t CFG_START_VALUE  = 2'd0;
  localparam cfg_index_t CFG_SETTLE_COUNT = 2'd1;
  localparam cfg_index_t CFG_MAX_EMIT     = 2'd2;
  localparam cfg_index_t CFG_MATCH_TOL    = 2'd3;

  // register reset values
  localparam logic [31:0] START_VALUE_RST  = 32'hC000_0000;
  localparam logic [15:0] SETTLE_COUNT_RST = 16'd4001;
  localparam logic [6:0]  MAX_EMIT_RST     = 7'd64;
  localparam logic [15:0] MATCH_TOL_RST    = 16'd4295;

  // fraction bits of the rate
  localparam int RATE_FRAC = 29;

  // datapath operation of a microcode step
  typedef logic [2:0] op_t;
  localparam op_t OP_NOP      = 3'd0;
  localparam op_t OP_LOAD     = 3'd1;
  localparam op_t OP_MUL_P    = 3'd2;
  localparam op_t OP_SETTLE_X = 3'd3;
  localparam op_t OP_MUL_X    = 3'd4;
  localparam op_t OP_REF      = 3'd5;
  localparam op_t OP_EMIT     = 3'd6;

  // sequencing condition of a microcode step
  typedef logic [2:0] cond_t;
  localparam cond_t COND_NEXT        = 3'd0;
  localparam cond_t COND_JUMP        = 3'd1;
  localparam cond_t COND_WAIT_IN     = 3'd2;
  localparam cond_t COND_SETTLE_ZERO = 3'd3;
  localparam cond_t COND_SETTLE_MORE = 3'd4;
  localparam cond_t COND_EMIT        = 3'd5;

  // microcode addresses
  typedef logic [3:0] upc_t;
  localparam upc_t UPC_IDLE   = 4'd0;
  localparam upc_t UPC_CHECK  = 4'd1;
  localparam upc_t UPC_S_PROD = 4'd2;
  localparam upc_t UPC_S_MAP  = 4'd3;
  localparam upc_t UPC_REF    = 4'd4;
  localparam upc_t UPC_E_PROD = 4'd5;
  localparam upc_t UPC_E_MAP  = 4'd6;
  localparam upc_t UPC_EMIT   = 4'd7;
  localparam upc_t UPC_DONE   = 4'd8;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  target;
  } uword_t;

  // datapath strobes from the sequencer
  typedef struct packed {
    logic load_start;
    logic mul_p;
    logic mul_x;
    logic load_ref;
  } dp_ctrl_t;

  // control store
  function automatic uword_t ucode(input upc_t addr);
    uword_t w;
    case (addr)
      UPC_IDLE:   w = '{op: OP_LOAD,     cond: COND_WAIT_IN,     target: UPC_IDLE};
      UPC_CHECK:  w = '{op: OP_NOP,      cond: COND_SETTLE_ZERO, target: UPC_REF};
      UPC_S_PROD: w = '{op: OP_MUL_P,    cond: COND_NEXT,        target: UPC_IDLE};
      UPC_S_MAP:  w = '{op: OP_SETTLE_X, cond: COND_SETTLE_MORE, target: UPC_S_PROD};
      UPC_REF:    w = '{op: OP_REF,      cond: COND_NEXT,        target: UPC_IDLE};
      UPC_E_PROD: w = '{op: OP_MUL_P,    cond: COND_NEXT,        target: UPC_IDLE};
      UPC_E_MAP:  w = '{op: OP_MUL_X,    cond: COND_NEXT,        target: UPC_IDLE};
      UPC_EMIT:   w = '{op: OP_EMIT,     cond: COND_EMIT,        target: UPC_E_PROD};
      UPC_DONE:   w = '{op: OP_NOP,      cond: COND_JUMP,        target: UPC_IDLE};
      default:    w = '{op: OP_NOP,      cond: COND_JUMP,        target: UPC_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/logistic_map_orbit_sampler.sv =====
// top level of the logistic map orbit sampler: sequencer, registers, result stage
//
//  channel | ports                                        | moves
//  --------+----------------------------------------------+------------------------------
//  in      | in_valid, in_ready, in_rate                  | one rate word per run
//  out     | out_valid, out_ready, out_rate_echo,         | 1..EMIT_LIMIT orbit words
//          | out_orbit_value, out_last_of_run, out_matched| per rate
//  cfg     | cfg_we, cfg_index, cfg_data                  | register write, no wait
//
// each map step is two passes through the one shared multiplier,
// sequenced by the microcode table
// a new rate is taken only when the previous run has finished
// reset clears the sequencer, counters and result stage; registers take defaults
// a stalled result stage holds the sequencer at its emit step
module logistic_map_orbit_sampler #(
  parameter int VALUE_BITS = 32,
  parameter int EMIT_LIMIT = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [31:0]                 in_rate,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [31:0]                 out_rate_echo,
  output logic [31:0]                 out_orbit_value,
  output logic                        out_last_of_run,
  output logic                        out_matched,
  input  logic                        cfg_we,
  input  lms_pkg::cfg_index_t         cfg_index,
  input  logic [31:0]                 cfg_data
);
  import lms_pkg::*;

  localparam int EW = $clog2(EMIT_LIMIT + 1);

  logic [31:0] start_value_r;
  logic [15:0] settle_count_r;
  logic [6:0]  max_emit_r;
  logic [15:0] match_tol_r;

  upc_t        upc_r, upc_nxt, upc_inc;
  uword_t      uw;
  logic [31:0] rate_r;
  logic [15:0] settle_left_r, settle_left_nxt;
  logic [EW-1:0] emit_left_r, emit_left_nxt;
  logic [6:0]  limit;

  logic        accept;
  logic        slot_free;
  logic        emit_fire;
  logic        hit;
  logic        last;
  logic [31:0] orbit_q32;
  dp_ctrl_t    ctrl;

  logic        out_valid_r;
  logic [31:0] out_rate_r;
  logic [31:0] out_value_r;
  logic        out_last_r;
  logic        out_match_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_value_r  <= START_VALUE_RST;
      settle_count_r <= SETTLE_COUNT_RST;
      max_emit_r     <= MAX_EMIT_RST;
      match_tol_r    <= MATCH_TOL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_VALUE:  start_value_r  <= cfg_data;
        CFG_SETTLE_COUNT: settle_count_r <= cfg_data[15:0];
        CFG_MAX_EMIT:     max_emit_r     <= cfg_data[6:0];
        CFG_MATCH_TOL:    match_tol_r    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // control word fetch and handshake terms
  assign uw        = ucode(upc_r);
  assign in_ready  = (uw.cond == COND_WAIT_IN);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign emit_fire = (uw.op == OP_EMIT) && slot_free;
  assign last      = hit || (emit_left_r == EW'(1));
  assign upc_inc   = upc_r + 4'd1;

  // emit limit clamped to 1..EMIT_LIMIT
  always_comb begin
    if (max_emit_r == 7'd0) begin
      limit = 7'd1;
    end else if (max_emit_r > 7'(EMIT_LIMIT)) begin
      limit = 7'(EMIT_LIMIT);
    end else begin
      limit = max_emit_r;
    end
  end

  // next microcode address
  always_comb begin
    case (uw.cond)
      COND_NEXT:        upc_nxt = upc_inc;
      COND_JUMP:        upc_nxt = uw.target;
      COND_WAIT_IN:     upc_nxt = accept ? upc_inc : upc_r;
      COND_SETTLE_ZERO: upc_nxt = (settle_left_r == 16'd0) ? uw.target : upc_inc;
      COND_SETTLE_MORE: upc_nxt = (settle_left_r != 16'd1) ? uw.target : upc_inc;
      COND_EMIT: begin
        if (!slot_free) begin
          upc_nxt = upc_r;
        end else if (last) begin
          upc_nxt = upc_inc;
        end else begin
          upc_nxt = uw.target;
        end
      end
      default:          upc_nxt = UPC_IDLE;
    endcase
  end

  // loop counters
  always_comb begin
    settle_left_nxt = settle_left_r;
    emit_left_nxt   = emit_left_r;
    if (accept) begin
      settle_left_nxt = settle_count_r;
      emit_left_nxt   = EW'(limit);
    end else begin
      if (uw.op == OP_SETTLE_X) begin
        settle_left_nxt = settle_left_r - 16'd1;
      end
      if (emit_fire) begin
        emit_left_nxt = emit_left_r - EW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r         <= UPC_IDLE;
      settle_left_r <= '0;
      emit_left_r   <= '0;
    end else begin
      upc_r         <= upc_nxt;
      settle_left_r <= settle_left_nxt;
      emit_left_r   <= emit_left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rate_r <= in_rate;
    end
  end

  // datapath strobes
  assign ctrl.load_start = (uw.op == OP_LOAD) && accept;
  assign ctrl.mul_p      = (uw.op == OP_MUL_P);
  assign ctrl.mul_x      = (uw.op == OP_MUL_X) || (uw.op == OP_SETTLE_X);
  assign ctrl.load_ref   = (uw.op == OP_REF);

  lms_datapath #(
    .VALUE_BITS(VALUE_BITS)
  ) u_datapath (
    .clk        (clk),
    .ctrl       (ctrl),
    .start_value(start_value_r),
    .rate       (rate_r),
    .match_tol  (match_tol_r),
    .orbit_q32  (orbit_q32),
    .hit        (hit)
  );

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_rate_r  <= rate_r;
      out_value_r <= orbit_q32;
      out_last_r  <= last;
      out_match_r <= hit;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_rate_echo   = out_rate_r;
  assign out_orbit_value = out_value_r;
  assign out_last_of_run = out_last_r;
  assign out_matched     = out_match_r;

endmodule

// ===== rtl/lms_datapath.sv =====
// map datapath: shared multiplier, x, product and reference registers, match compare
module lms_datapath #(
  parameter int VALUE_BITS = 32
) (
  input  logic             clk,
  input  lms_pkg::dp_ctrl_t ctrl,
  input  logic [31:0]      start_value,
  input  logic [31:0]      rate,
  input  logic [15:0]      match_tol,
  output logic [31:0]      orbit_q32,
  output logic             hit
);
  import lms_pkg::*;

  localparam int VB = VALUE_BITS;
  localparam int MA = (VB > 32) ? VB : 32;
  localparam int PW = MA + VB;

  logic [VB-1:0] x_r, x_nxt;
  logic [VB-1:0] p_r, p_nxt;
  logic [VB-1:0] ref_r, ref_nxt;
  logic [MA-1:0] mul_a;
  logic [VB-1:0] mul_b;
  logic [VB-1:0] mul_c;
  logic [PW-1:0] prod;
  logic          sat;
  logic [VB-1:0] x_map;
  logic [VB+31:0] start_ext;
  logic [VB+31:0] x_ext;
  logic [VB:0]   diff_up;
  logic [VB:0]   diff_dn;
  logic [VB-1:0] x_dist;

  // operand select: x*(1-x) as x*~x + x, or r*p
  always_comb begin
    if (ctrl.mul_x) begin
      mul_a = MA'(rate);
      mul_b = p_r;
      mul_c = '0;
    end else begin
      mul_a = MA'(x_r);
      mul_b = ~x_r;
      mul_c = x_r;
    end
  end

  assign prod = PW'(mul_a) * PW'(mul_b) + PW'(mul_c);

  // truncate and saturate just below 1.0
  assign sat   = |prod[PW-1:VB+RATE_FRAC];
  assign x_map = sat ? '1 : prod[VB+RATE_FRAC-1:RATE_FRAC];
  assign p_nxt = prod[2*VB-1:VB];

  // start value into the internal format
  assign start_ext = {start_value, {VB{1'b0}}};

  always_comb begin
    if (ctrl.load_start) begin
      x_nxt = start_ext[VB+31 -: VB];
    end else if (ctrl.mul_x) begin
      x_nxt = x_map;
    end else begin
      x_nxt = x_r;
    end
  end

  assign ref_nxt = ctrl.load_ref ? x_r : ref_r;

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    ref_r <= ref_nxt;
    if (ctrl.mul_p) begin
      p_r <= p_nxt;
    end
  end

  // distance to the reference
  assign diff_up = {1'b0, x_r} - {1'b0, ref_r};
  assign diff_dn = {1'b0, ref_r} - {1'b0, x_r};
  assign x_dist  = diff_up[VB] ? diff_dn[VB-1:0] : diff_up[VB-1:0];
  assign hit     = x_dist < VB'(match_tol);

  // internal x back to Q0.32
  assign x_ext     = {x_r, 32'b0};
  assign orbit_q32 = x_ext[VB+31 -: 32];

endmodule

// ===== rtl/lms_checker.sv =====
// port-level checks of the orbit sampler and their bind to the top level
module lms_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_rate_echo,
  input logic [31:0] out_orbit_value,
  input logic        out_last_of_run,
  input logic        out_matched
);

  // a stalled word holds its rate echo and orbit value
  property p_out_hold;
    @(posedge clk) disable iff (!rst_n)
      out_valid && !out_ready |=>
        out_valid && $stable(out_rate_echo) && $stable(out_orbit_value);
  endproperty
  a_out_hold: assert property (p_out_hold) else $error("stalled result word changed");

  // a match always ends the run
  property p_match_last;
    @(posedge clk) disable iff (!rst_n)
      out_valid && out_matched |-> out_last_of_run;
  endproperty
  a_match_last: assert property (p_match_last) else $error("match without last flag");

  // one run at a time: busy right after taking a rate
  property p_busy_after_accept;
    @(posedge clk) disable iff (!rst_n)
      in_valid && in_ready |=> !in_ready;
  endproperty
  a_busy_after_accept: assert property (p_busy_after_accept)
    else $error("rate taken while a run is active");

endmodule

bind logistic_map_orbit_sampler lms_checker u_lms_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_rate_echo  (out_rate_echo),
  .out_orbit_value(out_orbit_value),
  .out_last_of_run(out_last_of_run),
  .out_matched    (out_matched)
);

// ===== bench/logistic_map_orbit_sampler_tb.sv =====
// self-checking testbench for the logistic map orbit sampler
`timescale 1ns / 1ps

module logistic_map_orbit_sampler_tb;
  import lms_pkg::*;

  localparam int  RUN_LIMIT  = 2_500_000;
  localparam int  DRAIN_GAP  = 8;
  localparam int  TAIL_GAP   = 32;
  localparam int  EMIT_CAP   = 64;
  localparam int  GROUPS     = 6;
  localparam int  GROUP_SIZE = 5;
  localparam int  HOLD_LEN   = 2000;

  // one expected result word
  typedef struct {
    logic [31:0] rate;
    logic [31:0] value;
    logic        last;
    logic        matched;
  } orbit_word_t;

  // one rate to send, with an optional hand-written single-word result
  typedef struct {
    logic [31:0] rate;
    bit          typed;
    logic [31:0] t_value;
    logic        t_last;
    logic        t_matched;
  } rate_job_t;

  // directed row: optional register settings, the rate, optional typed result
  typedef struct packed {
    bit          new_cfg;
    logic [31:0] start;
    logic [15:0] settle;
    logic [6:0]  emit;
    logic [15:0] tol;
    logic [31:0] rate;
    bit          typed;
    logic [31:0] t_value;
    bit          t_last;
    bit          t_matched;
  } dir_row_t;

  localparam int DIR_ROWS = 18;

  dir_row_t dir_rows [0:DIR_ROWS-1] = '{
    // reset settings: zero rate collapses to zero and matches at once
    '{1'b0, 32'h0, 16'd0, 7'd0, 16'd0, 32'h0000_0000, 1'b1, 32'h0, 1'b1, 1'b1},
    '{1'b0, 32'h0, 16'd0, 7'd0, 16'd0, 32'h7000_0000, 1'b0, 32'h0, 1'b0, 1'b0},
    '{1'b0, 32'h0, 16'd0, 7'd0, 16'd0, 32'h8000_0000, 1'b0, 32'h0, 1'b0, 1'b0},
    // zero start stays at zero
    '{1'b1, 32'h0, 16'd10, 7'd64, 16'd4295, 32'h6AAA_AAAB, 1'b1, 32'h0, 1'b1, 1'b1},
    // zero tolerance never matches, one word limit ends the run
    '{1'b1, 32'h0, 16'd10, 7'd1, 16'd0, 32'h7000_0000, 1'b1, 32'h0, 1'b1, 1'b0},
    // full-scale start with no settling: reference far from the zero that follows
    '{1'b1, 32'hFFFF_FFFF, 16'd0, 7'd1, 16'd4295, 32'h4000_0000, 1'b1, 32'h0, 1'b1, 1'b0},
    // zero emit limit acts as one
    '{1'b1, 32'hFFFF_FFFF, 16'd0, 7'd0, 16'd4295, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b1, 1'b0},
    // emit limit above the cap, saturation at one half and rate four
    '{1'b1, 32'h8000_0000, 16'd0, 7'd127, 16'd0, 32'h8000_0000, 1'b0, 32'h0, 1'b0, 1'b0},
    '{1'b1, 32'hC000_0000, 16'd0, 7'd64, 16'hFFFF, 32'h6000_0000, 1'b0, 32'h0, 1'b0, 1'b0},
    '{1'b0, 32'h0, 16'd0, 7'd0, 16'd0, 32'h5555_5555, 1'b0, 32'h0, 1'b0, 1'b0},
    // rates above four, then lower rates under other settings
    '{1'b1, 32'h4000_0000, 16'd5, 7'd8, 16'd100, 32'hC000_0000, 1'b0, 32'h0, 1'b0, 1'b0},
    '{1'b0, 32'h0, 16'd0, 7'd0, 16'd0, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0, 1'b0},
    '{1'b1, 32'h0000_0001, 16'd3, 7'd64, 16'd4295, 32'h0000_0001, 1'b0, 32'h0, 1'b0, 1'b0},
    '{1'b1, 32'hC000_0000, 16'd100, 7'd64, 16'hFFFF, 32'h2000_0000, 1'b0, 32'h0, 1'b0, 1'b0},
    '{1'b1, 32'hC000_0000, 16'd16, 7'd64, 16'd0, 32'h5000_0000, 1'b0, 32'h0, 1'b0, 1'b0},
    '{1'b1, 32'h8000_0000, 16'd20, 7'd1, 16'd0, 32'h7A00_0000, 1'b0, 32'h0, 1'b0, 1'b0},
    // longest settling, then the reset settings again
    '{1'b1, 32'hC000_0000, 16'hFFFF, 7'd64, 16'hFFFF, 32'h5800_0000, 1'b0, 32'h0, 1'b0, 1'b0},
    '{1'b1, 32'hC000_0000, 16'd4001, 7'd64, 16'd4295, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0, 1'b0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_rate = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_rate_echo;
  logic [31:0] out_orbit_value;
  logic        out_last_of_run;
  logic        out_matched;
  logic        cfg_we = 1'b0;
  cfg_index_t  cfg_index = CFG_START_VALUE;
  logic [31:0] cfg_data = '0;

  // register copies seen by the predictor
  logic [31:0] start_cfg  = START_VALUE_RST;
  logic [15:0] settle_cfg = SETTLE_COUNT_RST;
  logic [6:0]  emit_cfg   = MAX_EMIT_RST;
  logic [15:0] tol_cfg    = MATCH_TOL_RST;

  // block state as the predictor tracks it
  logic [31:0] orbit_x;
  logic [31:0] orbit_ref;
  logic [31:0] orbit_rate;
  logic [15:0] settle_steps;
  logic [6:0]  words_emitted;

  orbit_word_t expected_orbit [$];
  rate_job_t   rate_feed [$];
  rate_job_t   job_on_wire;
  orbit_word_t want;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  int items_queued = 0;
  int items_taken = 0;
  int error_count = 0;
  int cycle_count = 0;

  logistic_map_orbit_sampler i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rate         (in_rate),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_rate_echo   (out_rate_echo),
    .out_orbit_value (out_orbit_value),
    .out_last_of_run (out_last_of_run),
    .out_matched     (out_matched),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // one map step: x' = r * (x * (1 - x)), both products truncated and saturated
  function automatic logic [31:0] logistic_step(input logic [31:0] x, input logic [31:0] r);
    logic [32:0] one_minus;
    logic [65:0] x_prod;
    logic [31:0] p;
    logic [63:0] r_prod;
    logic [34:0] nx;
    one_minus = 33'h1_0000_0000 - {1'b0, x};
    x_prod = x * one_minus;
    p = (x_prod[65:32] > 34'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : x_prod[63:32];
    r_prod = r * p;
    nx = r_prod[63:29];
    return (nx > 35'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : nx[31:0];
  endfunction

  // settle, take the reference, then queue the orbit words up to the first match or the emit limit
  task automatic predict_orbit(input logic [31:0] r, input bit keep);
    logic [31:0] x;
    logic [31:0] diff;
    int lim;
    int n;
    int i;
    bit hit;
    x = start_cfg;
    n = 0;
    lim = (emit_cfg == 7'd0) ? 1 : ((emit_cfg > EMIT_CAP) ? EMIT_CAP : int'(emit_cfg));
    for (i = 0; i < settle_cfg; i++) x = logistic_step(x, r);
    orbit_ref = x;
    for (i = 0; i < lim; i++) begin
      x = logistic_step(x, r);
      diff = (x > orbit_ref) ? x - orbit_ref : orbit_ref - x;
      hit = diff < {16'h0, tol_cfg};
      n++;
      if (keep) expected_orbit.push_back('{r, x, hit || (i + 1 == lim), hit});
      if (hit) break;
    end
    orbit_rate = r;
    orbit_x = x;
    settle_steps = settle_cfg;
    words_emitted = n[6:0];
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("mismatch at cycle %0d on %s: got %h, expected %h",
             cycle_count, what, got, exp_val);
    error_count++;
  endtask

  // rate sender: valid holds until taken, random gaps between words
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      predict_orbit(job_on_wire.rate, !job_on_wire.typed);
      if (job_on_wire.typed)
        expected_orbit.push_back('{job_on_wire.rate, job_on_wire.t_value,
                                   job_on_wire.t_last, job_on_wire.t_matched});
      items_taken++;
    end
    if (in_valid && !in_ready && rst_n) begin
      // word still pending
    end else if (rate_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
      job_on_wire = rate_feed.pop_front();
      in_valid <= 1'b1;
      in_rate <= job_on_wire.rate;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result receiver: compare each word with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_orbit.size() == 0) begin
        report_mismatch("word with nothing expected", out_orbit_value, 32'h0);
      end else begin
        want = expected_orbit.pop_front();
        if (out_rate_echo !== want.rate)
          report_mismatch("rate_echo", out_rate_echo, want.rate);
        if (out_orbit_value !== want.value)
          report_mismatch("orbit_value", out_orbit_value, want.value);
        if (out_last_of_run !== want.last)
          report_mismatch("last_of_run", {31'h0, out_last_of_run}, {31'h0, want.last});
        if (out_matched !== want.matched)
          report_mismatch("matched", {31'h0, out_matched}, {31'h0, want.matched});
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_cfg_reg(input cfg_index_t idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      CFG_START_VALUE:  start_cfg = data;
      CFG_SETTLE_COUNT: settle_cfg = data[15:0];
      CFG_MAX_EMIT:     emit_cfg = data[6:0];
      CFG_MATCH_TOL:    tol_cfg = data[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // all four registers; junk fills the unused upper bits
  task automatic load_settings(input logic [31:0] start, input logic [15:0] settle,
                               input logic [6:0] emit, input logic [15:0] tol,
                               input logic [31:0] junk);
    write_cfg_reg(CFG_START_VALUE, start);
    write_cfg_reg(CFG_SETTLE_COUNT, {junk[31:16], settle});
    write_cfg_reg(CFG_MAX_EMIT, {junk[31:7], emit});
    write_cfg_reg(CFG_MATCH_TOL, {junk[31:16], tol});
    cfg_we <= 1'b0;
  endtask

  // wait for every queued rate to be taken and every word to come back
  task automatic wait_idle();
    while (items_taken != items_queued || expected_orbit.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic queue_rate(input rate_job_t job);
    rate_feed.push_back(job);
    items_queued++;
  endtask

  // mostly short settling so the run stays short, now and then a longer one
  task automatic random_settings();
    logic [31:0] start;
    logic [15:0] settle;
    logic [6:0]  emit;
    logic [15:0] tol;
    int pick;
    pick = $urandom_range(99);
    start = (pick < 15) ? START_VALUE_RST : $urandom;
    pick = $urandom_range(99);
    if (pick < 40) settle = 16'($urandom_range(0, 8));
    else if (pick < 90) settle = 16'($urandom_range(9, 200));
    else settle = 16'($urandom_range(201, 1500));
    pick = $urandom_range(99);
    emit = (pick < 15) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(1, EMIT_CAP));
    pick = $urandom_range(99);
    if (pick < 20) tol = 16'd0;
    else if (pick < 60) tol = 16'($urandom_range(0, 5000));
    else tol = 16'($urandom_range(0, 65535));
    load_settings(start, settle, emit, tol, $urandom);
  endtask

  // rates mostly in the periodic and chaotic band, some low, some past four
  function automatic logic [31:0] random_rate();
    int pick;
    pick = $urandom_range(99);
    if (pick < 50) return $urandom_range(32'h6000_0000, 32'h8000_0000);
    if (pick < 70) return $urandom_range(32'h0, 32'h6000_0000);
    if (pick < 78) return 32'h8000_0000;
    return $urandom;
  endfunction

  // stimulus
  initial begin
    rate_job_t job;
    int k;
    int phase;
    int grp;
    int n;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 9;
    recv_idle_pct = 88;

    // directed table
    for (k = 0; k < DIR_ROWS; k++) begin
      if (dir_rows[k].new_cfg) begin
        wait_idle();
        load_settings(dir_rows[k].start, dir_rows[k].settle, dir_rows[k].emit,
                      dir_rows[k].tol, 32'h0);
      end
      job = '{dir_rows[k].rate, dir_rows[k].typed, dir_rows[k].t_value,
              dir_rows[k].t_last, dir_rows[k].t_matched};
      queue_rate(job);
    end
    wait_idle();

    // random groups under three idling mixes
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 9;  recv_idle_pct = 88; end
        1: begin send_idle_pct = 88; recv_idle_pct = 9;  end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (grp = 0; grp < GROUPS; grp++) begin
        random_settings();
        // long receiver stall while rates keep coming
        if (phase == 2 && grp == 1) hold_left = HOLD_LEN;
        for (n = 0; n < GROUP_SIZE; n++) begin
          job = '{random_rate(), 1'b0, 32'h0, 1'b0, 1'b0};
          queue_rate(job);
        end
        wait_idle();
      end
    end

    repeat (TAIL_GAP) @(posedge clk);
    if (error_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
